// ----- rtl/ftsm_pkg.sv -----
// Shared constants and types for the four-thruster stick mixer.
// Used by ftsm_isqrt, ftsm_div and four_thruster_stick_mixer_core; no dependencies.
`default_nettype none

package ftsm_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_DEAD_ZONE      = 2'd0;
  localparam logic [1:0] REG_DIRECTION_GAIN = 2'd1;
  localparam logic [1:0] REG_YAW_GAIN       = 2'd2;
  localparam logic [1:0] REG_DRIVE_LIMIT    = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  // Reset values of the registers
  localparam logic [14:0] DEAD_ZONE_RST      = 15'd3932;
  localparam logic [7:0]  DIRECTION_GAIN_RST = 8'd140;
  localparam logic [6:0]  YAW_GAIN_RST       = 7'd20;
  localparam logic [6:0]  DRIVE_LIMIT_RST    = 7'd100;

  // Q1.15 constants
  localparam logic [16:0] ONE_Q15       = 17'd32768;
  localparam logic [14:0] INV_SQRT2_Q15 = 15'd23170;

  // Square root: 32-bit radicand, one result bit per iteration
  localparam int SQRT_RAD_W = 32;
  localparam int SQRT_ITER  = 16;
  localparam int SQRT_STEPS = 2;

  // Dividers: 31-bit dividend, 16-bit divisor
  localparam int DIV_NUM_W = 31;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_STEPS = 4;

  localparam int NUM_MOTORS = 4;

  // Per-item sideband carried beside the dividers
  typedef struct packed {
    logic [NUM_MOTORS-1:0] c_neg;
    logic                  mr_zero;
  } div_side_t;

endpackage

`default_nettype wire

// ----- rtl/ftsm_isqrt.sv -----
// Pipelined integer square root, STEPS result bits per register stage.
// Depends on ftsm_pkg for the radicand width and the iteration count.
`default_nettype none

module ftsm_isqrt #(
  parameter int STEPS = ftsm_pkg::SQRT_STEPS
) (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [ftsm_pkg::SQRT_RAD_W-1:0] rad_i,
  output logic [ftsm_pkg::SQRT_ITER-1:0]       root_o
);

  localparam int RW  = ftsm_pkg::SQRT_RAD_W;
  localparam int LAT = (ftsm_pkg::SQRT_ITER + STEPS - 1) / STEPS;

  logic [RW-1:0] v_q [LAT];
  logic [RW-1:0] r_q [LAT];

  for (genvar st = 0; st < LAT; st++) begin : g_stage
    logic [RW-1:0] v_in;
    logic [RW-1:0] r_in;
    logic [RW-1:0] v_d;
    logic [RW-1:0] r_d;

    // Take the radicand at the head, the previous stage's remainder and root elsewhere
    if (st == 0) begin : g_head
      assign v_in = rad_i;
      assign r_in = '0;
    end else begin : g_body
      assign v_in = v_q[st-1];
      assign r_in = r_q[st-1];
    end

    // Run STEPS digit-by-digit iterations on this stage's remainder
    always_comb begin
      logic [RW-1:0] v;
      logic [RW-1:0] r;
      logic [RW-1:0] b;
      int            k;
      v = v_in;
      r = r_in;
      for (int j = 0; j < STEPS; j++) begin
        k = st * STEPS + j;
        if (k < ftsm_pkg::SQRT_ITER) begin
          b = RW'(1) << (RW - 2 - 2 * k);
          if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
        end
      end
      v_d = v;
      r_d = r;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[st] <= v_d;
        r_q[st] <= r_d;
      end
    end
  end

  assign root_o = r_q[LAT-1][ftsm_pkg::SQRT_ITER-1:0];

endmodule

`default_nettype wire

// ----- rtl/ftsm_div.sv -----
// Pipelined restoring unsigned divider, STEPS quotient bits per register stage.
// Depends on ftsm_pkg for the default operand widths.
`default_nettype none

module ftsm_div #(
  parameter int NUM_W = ftsm_pkg::DIV_NUM_W,
  parameter int DEN_W = ftsm_pkg::DIV_DEN_W,
  parameter int STEPS = ftsm_pkg::DIV_STEPS
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int LAT   = (NUM_W + STEPS - 1) / STEPS;
  localparam int TOT_W = LAT * STEPS;

  // Dividend bits leave at the top while quotient bits enter at the bottom
  logic [TOT_W-1:0] nq_q  [LAT];
  logic [DEN_W-1:0] rem_q [LAT];
  logic [DEN_W-1:0] den_q [LAT];

  for (genvar st = 0; st < LAT; st++) begin : g_stage
    logic [TOT_W-1:0] nq_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [TOT_W-1:0] nq_d;
    logic [DEN_W-1:0] rem_d;
    logic [DEN_W-1:0] den_d;

    // Take the operands at the head, the previous stage's state elsewhere
    if (st == 0) begin : g_head
      assign nq_in  = TOT_W'(num_i);
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_body
      assign nq_in  = nq_q[st-1];
      assign rem_in = rem_q[st-1];
      assign den_in = den_q[st-1];
    end

    always_comb begin
      logic [TOT_W-1:0] nq;
      logic [DEN_W-1:0] rem;
      logic [DEN_W:0]   t;
      nq    = nq_in;
      rem   = rem_in;
      den_d = den_in;
      for (int j = 0; j < STEPS; j++) begin
        t  = {rem, nq[TOT_W-1]};
        nq = nq << 1;
        if (t >= {1'b0, den_d}) begin
          t     = t - {1'b0, den_d};
          nq[0] = 1'b1;
        end
        rem = t[DEN_W-1:0];
      end
      nq_d  = nq;
      rem_d = rem;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[st]  <= nq_d;
        rem_q[st] <= rem_d;
        den_q[st] <= den_d;
      end
    end
  end

  assign quo_o = nq_q[LAT-1][NUM_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/four_thruster_stick_mixer_core.sv -----
// Top level of the four-thruster stick mixer: stick sample in, four drives out.
// Depends on ftsm_pkg, ftsm_isqrt and ftsm_div.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+--------------------------------------
//  in       | in        | in_valid_i/in_stall_o   | stick_x_i, stick_y_i, yaw_axis_i
//  out      | out       | out_valid_o/out_stall_i | front_right_drive_o, front_left_drive_o,
//           |           |                        |   back_left_drive_o, back_right_drive_o
//  cfg      | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One item enters per cycle while no held result stalls the pipe; the pipe holds
// 8 + SQ_LAT + DIV_LAT register stages (24 with the default step counts).
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stalled result freezes the whole pipeline; in_stall_o follows out_stall_i
// while a result is held, so nothing is dropped or repeated.
`default_nettype none

module four_thruster_stick_mixer_core #(
  parameter int SQRT_STEPS = ftsm_pkg::SQRT_STEPS,
  parameter int DIV_STEPS  = ftsm_pkg::DIV_STEPS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [15:0]                stick_x_i,
  input  wire logic signed [15:0]                stick_y_i,
  input  wire logic signed [15:0]                yaw_axis_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [7:0]                      front_right_drive_o,
  output logic signed [7:0]                      front_left_drive_o,
  output logic signed [7:0]                      back_left_drive_o,
  output logic signed [7:0]                      back_right_drive_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [ftsm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ftsm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int NM      = ftsm_pkg::NUM_MOTORS;
  localparam int SQ_LAT  = (ftsm_pkg::SQRT_ITER + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int DIV_LAT = (ftsm_pkg::DIV_NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int YAW_DL  = SQ_LAT + 1 + DIV_LAT;
  localparam int NSTAGE  = 2 + SQ_LAT + 1 + DIV_LAT + 4 + 1;

  // ---------------------------------------------------------------- config
  logic [14:0] dead_zone_q;
  logic [7:0]  dir_gain_q;
  logic [6:0]  yaw_gain_q;
  logic [6:0]  limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= ftsm_pkg::DEAD_ZONE_RST;
      dir_gain_q  <= ftsm_pkg::DIRECTION_GAIN_RST;
      yaw_gain_q  <= ftsm_pkg::YAW_GAIN_RST;
      limit_q     <= ftsm_pkg::DRIVE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ftsm_pkg::REG_DEAD_ZONE:      dead_zone_q <= cfg_data_i[14:0];
        ftsm_pkg::REG_DIRECTION_GAIN: dir_gain_q  <= cfg_data_i[7:0];
        ftsm_pkg::REG_YAW_GAIN:       yaw_gain_q  <= cfg_data_i[6:0];
        ftsm_pkg::REG_DRIVE_LIMIT:    limit_q     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  logic en;
  logic vld_q [NSTAGE];

  assign en         = !(vld_q[NSTAGE-1] && out_stall_i);
  assign in_stall_o = !en;

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTAGE; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NSTAGE; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // ---------------------------------------------------------------- stage a
  logic signed [15:0] x_a, y_a, yaw_a;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_a   <= stick_x_i;
      y_a   <= stick_y_i;
      yaw_a <= yaw_axis_i;
    end
  end

  // ---------------------------------------------------------------- stage b
  // Square the axes and form the per-motor direction sums
  logic signed [31:0] xx, yy;
  logic signed [17:0] xs, ys;
  logic        [31:0] sq_b;
  logic signed [17:0] s_b [NM];
  logic signed [15:0] yaw_b;

  assign xx = x_a * x_a;
  assign yy = y_a * y_a;
  assign xs = 18'(x_a);
  assign ys = 18'(y_a);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_b   <= 32'(xx) + 32'(yy);
      s_b[0] <= -xs - ys;
      s_b[1] <= xs - ys;
      s_b[2] <= xs + ys;
      s_b[3] <= ys - xs;
      yaw_b  <= yaw_a;
    end
  end

  // ---------------------------------------------------------------- square root
  logic [15:0] mr_c;

  ftsm_isqrt #(
    .STEPS(SQRT_STEPS)
  ) u_isqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (sq_b),
    .root_o(mr_c)
  );

  logic signed [17:0] s_dl   [SQ_LAT][NM];
  logic signed [15:0] yaw_dl [YAW_DL];

  // Hold the sums beside the square root, and yaw beside the square root and dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int m = 0; m < NM; m++) s_dl[0][m] <= s_b[m];
      for (int i = 1; i < SQ_LAT; i++) begin
        for (int m = 0; m < NM; m++) s_dl[i][m] <= s_dl[i-1][m];
      end
      yaw_dl[0] <= yaw_b;
      for (int i = 1; i < YAW_DL; i++) yaw_dl[i] <= yaw_dl[i-1];
    end
  end

  // ---------------------------------------------------------------- stage e
  // Clamp the magnitude, set up the dead-zone remap and cosine dividends
  logic [16:0] m_c;
  logic [16:0] dz_ext;
  logic [16:0] abs_s [NM];

  logic [30:0]         dnum_e;
  logic [15:0]         dden_e;
  logic [30:0]         cnum_e [NM];
  logic [15:0]         mr_e;
  ftsm_pkg::div_side_t side_e;

  assign m_c    = ({1'b0, mr_c} > ftsm_pkg::ONE_Q15) ? ftsm_pkg::ONE_Q15 : {1'b0, mr_c};
  assign dz_ext = {2'b00, dead_zone_q};

  always_comb begin
    for (int m = 0; m < NM; m++) begin
      abs_s[m] = s_dl[SQ_LAT-1][m][17] ? 17'(-s_dl[SQ_LAT-1][m])
                                       : s_dl[SQ_LAT-1][m][16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dnum_e <= (m_c >= dz_ext) ? 31'({m_c - dz_ext, 15'd0}) : '0;
      dden_e <= 16'(ftsm_pkg::ONE_Q15 - dz_ext);
      for (int m = 0; m < NM; m++) begin
        cnum_e[m]       <= 31'(abs_s[m]) * 31'(ftsm_pkg::INV_SQRT2_Q15);
        side_e.c_neg[m] <= s_dl[SQ_LAT-1][m][17];
      end
      side_e.mr_zero <= (mr_c == '0);
      mr_e           <= mr_c;
    end
  end

  // ---------------------------------------------------------------- dividers
  logic [30:0] dq_q;
  logic [30:0] cq_q [NM];

  ftsm_div #(
    .NUM_W(ftsm_pkg::DIV_NUM_W),
    .DEN_W(ftsm_pkg::DIV_DEN_W),
    .STEPS(DIV_STEPS)
  ) u_div_d (
    .clk_i(clk_i),
    .en_i (en),
    .num_i(dnum_e),
    .den_i(dden_e),
    .quo_o(dq_q)
  );

  for (genvar m = 0; m < NM; m++) begin : g_cdiv
    ftsm_div #(
      .NUM_W(ftsm_pkg::DIV_NUM_W),
      .DEN_W(ftsm_pkg::DIV_DEN_W),
      .STEPS(DIV_STEPS)
    ) u_div_c (
      .clk_i(clk_i),
      .en_i (en),
      .num_i(cnum_e[m]),
      .den_i(mr_e),
      .quo_o(cq_q[m])
    );
  end

  ftsm_pkg::div_side_t side_dl [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dl[0] <= side_e;
      for (int i = 1; i < DIV_LAT; i++) side_dl[i] <= side_dl[i-1];
    end
  end

  // ---------------------------------------------------------------- stage f
  // Sign the cosines, apply direction and yaw gains
  logic signed [17:0] c_f [NM];
  logic        [16:0] d_c;
  logic signed [15:0] yaw_f;
  logic signed [25:0] gc_f [NM];
  logic signed [23:0] yt_f;
  logic        [16:0] d_f;

  assign yaw_f = yaw_dl[YAW_DL-1];
  assign d_c   = (dq_q > 31'(ftsm_pkg::ONE_Q15)) ? ftsm_pkg::ONE_Q15 : dq_q[16:0];

  always_comb begin
    for (int m = 0; m < NM; m++) begin
      if (side_dl[DIV_LAT-1].mr_zero) begin
        c_f[m] = '0;
      end else if (side_dl[DIV_LAT-1].c_neg[m]) begin
        c_f[m] = -$signed({1'b0, cq_q[m][16:0]});
      end else begin
        c_f[m] = $signed({1'b0, cq_q[m][16:0]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int m = 0; m < NM; m++) begin
        gc_f[m] <= $signed({1'b0, dir_gain_q}) * c_f[m];
      end
      yt_f <= $signed({1'b0, yaw_gain_q}) * yaw_f;
      d_f  <= d_c;
    end
  end

  // ---------------------------------------------------------------- stage g
  // Clamp the direction term to the drive limit in Q.15
  logic signed [25:0] plim;
  logic signed [22:0] p_g [NM];
  logic        [16:0] d_g;
  logic signed [23:0] yt_g;

  assign plim = $signed({4'd0, limit_q, 15'd0});

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int m = 0; m < NM; m++) begin
        if (gc_f[m] > plim) begin
          p_g[m] <= 23'(plim);
        end else if (gc_f[m] < -plim) begin
          p_g[m] <= 23'(-plim);
        end else begin
          p_g[m] <= 23'(gc_f[m]);
        end
      end
      d_g  <= d_f;
      yt_g <= yt_f;
    end
  end

  // ---------------------------------------------------------------- stage h
  // Scale by the remapped magnitude
  logic signed [39:0] pd_h [NM];
  logic signed [23:0] yt_h;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int m = 0; m < NM; m++) begin
        pd_h[m] <= p_g[m] * $signed({1'b0, d_g});
      end
      yt_h <= yt_g;
    end
  end

  // ---------------------------------------------------------------- stage i
  // Truncate toward zero by 2^30 and negate
  logic signed [39:0] pd_rnd [NM];
  logic signed [8:0]  base_i [NM];
  logic signed [23:0] yt_i;

  always_comb begin
    for (int m = 0; m < NM; m++) begin
      pd_rnd[m] = pd_h[m][39] ? pd_h[m] + 40'sh3FFF_FFFF : pd_h[m];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int m = 0; m < NM; m++) base_i[m] <= -9'(pd_rnd[m] >>> 30);
      yt_i <= yt_h;
    end
  end

  // ---------------------------------------------------------------- output
  // Add the yaw term, truncate, clamp to the limit
  logic signed [25:0] num_o [NM];
  logic signed [25:0] num_r [NM];
  logic signed [10:0] sum_o [NM];
  logic signed [10:0] lim_s;
  logic signed [7:0]  drv_d [NM];
  logic signed [7:0]  drv_q [NM];

  assign lim_s = $signed({4'd0, limit_q});

  always_comb begin
    for (int m = 0; m < NM; m++) begin
      // front right and back left add yaw, the other two subtract it
      if (m == 0 || m == 2) begin
        num_o[m] = $signed({base_i[m], 15'd0}) + 26'(yt_i);
      end else begin
        num_o[m] = $signed({base_i[m], 15'd0}) - 26'(yt_i);
      end
      num_r[m] = num_o[m][25] ? num_o[m] + 26'sd32767 : num_o[m];
      sum_o[m] = 11'(num_r[m] >>> 15);
      if (sum_o[m] > lim_s) begin
        drv_d[m] = 8'(lim_s);
      end else if (sum_o[m] < -lim_s) begin
        drv_d[m] = 8'(-lim_s);
      end else begin
        drv_d[m] = 8'(sum_o[m]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int m = 0; m < NM; m++) drv_q[m] <= drv_d[m];
    end
  end

  assign out_valid_o         = vld_q[NSTAGE-1];
  assign front_right_drive_o = drv_q[0];
  assign front_left_drive_o  = drv_q[1];
  assign back_left_drive_o   = drv_q[2];
  assign back_right_drive_o  = drv_q[3];

`ifndef SYNTHESIS
  // Delivered drives stay within the programmed limit
  a_fr_fl_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (front_right_drive_o <= $signed({1'b0, limit_q}))
                 && (front_right_drive_o >= -$signed({1'b0, limit_q}))
                 && (front_left_drive_o <= $signed({1'b0, limit_q}))
                 && (front_left_drive_o >= -$signed({1'b0, limit_q})))
    else $error("front drive beyond limit");

  a_bl_br_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (back_left_drive_o <= $signed({1'b0, limit_q}))
                 && (back_left_drive_o >= -$signed({1'b0, limit_q}))
                 && (back_right_drive_o <= $signed({1'b0, limit_q}))
                 && (back_right_drive_o >= -$signed({1'b0, limit_q})))
    else $error("back drive beyond limit");

  // A held result freezes the pipe, so it is still valid next cycle
  a_hold_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(vld_q[NSTAGE-2])))
    else $error("pipeline moved under stall");
`endif

endmodule

`default_nettype wire
